>>> src/asc_pkg.sv
// Shared constants and tables for the angle to sin/cos DAC serializer.
package asc_pkg;

    localparam int ANGLE_W = 16;
    localparam int CPV_W   = 20;
    localparam int Z_W     = 21;
    localparam int XY_W    = 20;
    localparam int VOLT_W  = 17;
    localparam int PROD_W  = VOLT_W + CPV_W;
    localparam int STEP_W  = 4;
    localparam int STEPS   = 16;

    localparam logic signed [Z_W-1:0]  PI_Q16      = 21'sd205887;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [XY_W-1:0] CORDIC_K    = 20'sd39796;
    localparam logic signed [XY_W-1:0] VOLT_OFS    = 20'sd40960;

    localparam logic [PROD_W:0] ROUND_HALF  = (PROD_W+1)'(1) << 21;
    localparam int              CODE_SHIFT  = 22;

    localparam logic [15:0] HDR_CH_B = 16'h5000;
    localparam logic [15:0] HDR_CH_A = 16'hC000;

    localparam logic [CPV_W-1:0] CPV_RESET = 20'd256000;

    // arctangent of 2^-i, 1.0 rad = 65536
    function automatic logic [15:0] atan_q16(input logic [STEP_W-1:0] i);
        logic [15:0] r;
        unique case (i)
            4'd0:    r = 16'd51472;
            4'd1:    r = 16'd30386;
            4'd2:    r = 16'd16055;
            4'd3:    r = 16'd8150;
            4'd4:    r = 16'd4091;
            4'd5:    r = 16'd2047;
            4'd6:    r = 16'd1024;
            4'd7:    r = 16'd512;
            4'd8:    r = 16'd256;
            4'd9:    r = 16'd128;
            4'd10:   r = 16'd64;
            4'd11:   r = 16'd32;
            4'd12:   r = 16'd16;
            4'd13:   r = 16'd8;
            4'd14:   r = 16'd4;
            default: r = 16'd2;
        endcase
        return r;
    endfunction

endpackage

>>> src/asc_front.sv
// Front end: angle buffer, range reduction, iterative CORDIC, DAC code scaling.
module asc_front #(
    parameter int CODE_BITS = 12,
    parameter int WORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [15:0]            i_angle,
    input  logic [asc_pkg::CPV_W-1:0]     i_codes_per_volt,
    input  logic                          i_q_full,
    output logic                          o_push,
    output logic [2*WORD_BITS-1:0]        o_push_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_ROT  = 3'd2;
    localparam logic [2:0] ST_VOLT = 3'd3;
    localparam logic [2:0] ST_MULC = 3'd4;
    localparam logic [2:0] ST_MULS = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    localparam int ZW = asc_pkg::Z_W;
    localparam int XW = asc_pkg::XY_W;
    localparam int VW = asc_pkg::VOLT_W;
    localparam int PW = asc_pkg::PROD_W;

    logic                                r_in_valid, n_in_valid;
    logic signed [15:0]                  r_angle;
    logic [2:0]                          r_state, n_state;
    logic signed [ZW-1:0]                r_z, n_z;
    logic signed [XW-1:0]                r_x, n_x, r_y, n_y;
    logic                                r_neg, n_neg;
    logic [asc_pkg::STEP_W-1:0]          r_step, n_step;
    logic [VW-1:0]                       r_volt_c, r_volt_s, n_volt_c, n_volt_s;
    logic [PW-1:0]                       r_prod, n_prod;
    logic [CODE_BITS-1:0]                r_code_c, n_code_c;

    logic signed [XW-1:0]                x_sh, y_sh;
    logic signed [ZW-1:0]                atan_v;
    logic [PW:0]                         prod_rnd;
    logic [CODE_BITS-1:0]                code_now;
    logic [WORD_BITS-1:0]                word_c, word_s;

    function automatic logic [VW-1:0] volt_of(input logic signed [XW-1:0] v,
                                              input logic neg);
        logic signed [XW-1:0] vs;
        logic signed [XW-1:0] q;
        logic signed [XW-1:0] volt;
        vs   = neg ? -v : v;
        q    = (vs + XW'(2)) >>> 2;
        volt = (q <<< 1) + asc_pkg::VOLT_OFS;
        return volt[XW-1] ? '0 : volt[VW-1:0];
    endfunction

    assign o_ready = !r_in_valid;

    assign x_sh     = r_x >>> r_step;
    assign y_sh     = r_y >>> r_step;
    assign atan_v   = ZW'(asc_pkg::atan_q16(r_step));
    assign prod_rnd = {1'b0, r_prod} + asc_pkg::ROUND_HALF;
    assign code_now = prod_rnd[asc_pkg::CODE_SHIFT +: CODE_BITS];

    assign word_c = (WORD_BITS'(asc_pkg::HDR_CH_B) << (WORD_BITS - 16))
                  | WORD_BITS'(r_code_c);
    assign word_s = (WORD_BITS'(asc_pkg::HDR_CH_A) << (WORD_BITS - 16))
                  | WORD_BITS'(code_now);

    assign o_push      = (r_state == ST_FIN) && !i_q_full;
    assign o_push_data = {word_c, word_s};

    always_comb begin
        n_in_valid = r_in_valid;
        n_state    = r_state;
        n_z        = r_z;
        n_x        = r_x;
        n_y        = r_y;
        n_neg      = r_neg;
        n_step     = r_step;
        n_volt_c   = r_volt_c;
        n_volt_s   = r_volt_s;
        n_prod     = r_prod;
        n_code_c   = r_code_c;
        if (i_valid && o_ready) begin
            n_in_valid = 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (r_in_valid) begin
                    n_in_valid = 1'b0;
                    n_z        = ZW'(r_angle) <<< 4;
                    n_neg      = 1'b0;
                    n_state    = ST_RED;
                end
            end
            ST_RED: begin
                priority if (r_z > asc_pkg::HALF_PI_Q16) begin
                    n_z   = r_z - asc_pkg::PI_Q16;
                    n_neg = !r_neg;
                end else if (r_z < -asc_pkg::HALF_PI_Q16) begin
                    n_z   = r_z + asc_pkg::PI_Q16;
                    n_neg = !r_neg;
                end else begin
                    n_x     = asc_pkg::CORDIC_K;
                    n_y     = '0;
                    n_step  = '0;
                    n_state = ST_ROT;
                end
            end
            ST_ROT: begin
                if (!r_z[ZW-1]) begin
                    n_x = r_x - y_sh;
                    n_y = r_y + x_sh;
                    n_z = r_z - atan_v;
                end else begin
                    n_x = r_x + y_sh;
                    n_y = r_y - x_sh;
                    n_z = r_z + atan_v;
                end
                n_step = r_step + 1'b1;
                if (r_step == asc_pkg::STEP_W'(asc_pkg::STEPS - 1)) begin
                    n_state = ST_VOLT;
                end
            end
            ST_VOLT: begin
                n_volt_c = volt_of(r_x, r_neg);
                n_volt_s = volt_of(r_y, r_neg);
                n_state  = ST_MULC;
            end
            ST_MULC: begin
                n_prod  = PW'(r_volt_c) * PW'(i_codes_per_volt);
                n_state = ST_MULS;
            end
            ST_MULS: begin
                n_code_c = code_now;
                n_prod   = PW'(r_volt_s) * PW'(i_codes_per_volt);
                n_state  = ST_FIN;
            end
            ST_FIN: begin
                if (!i_q_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= ST_IDLE;
        end else begin
            r_in_valid <= n_in_valid;
            r_state    <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_angle <= i_angle;
        end
        r_z      <= n_z;
        r_x      <= n_x;
        r_y      <= n_y;
        r_neg    <= n_neg;
        r_step   <= n_step;
        r_volt_c <= n_volt_c;
        r_volt_s <= n_volt_s;
        r_prod   <= n_prod;
        r_code_c <= n_code_c;
    end

endmodule

>>> src/asc_queue.sv
// Two-entry queue of DAC word pairs between front and back end.
module asc_queue #(
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr, r_rd;
    logic [1:0]        r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> src/asc_back.sv
// Back end: shifts the word pair out MSB first, one bit word per handshake.
module asc_back #(
    parameter int WORD_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  logic [2*WORD_BITS-1:0] i_q_data,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_serial_bit,
    output logic                   o_word_select,
    output logic                   o_word_end,
    output logic                   o_last
);

    localparam int BITS  = 2 * WORD_BITS;
    localparam int CNT_W = $clog2(BITS);

    logic                r_active;
    logic [BITS-1:0]     r_shift;
    logic [CNT_W-1:0]    r_cnt;
    logic                take;
    logic                is_last;

    assign take    = r_active && i_ready;
    assign is_last = (r_cnt == CNT_W'(BITS - 1));
    assign o_pop   = (!r_active || (take && is_last)) && !i_q_empty;

    assign o_valid       = r_active;
    assign o_serial_bit  = r_shift[BITS-1];
    assign o_word_select = (r_cnt >= CNT_W'(WORD_BITS));
    assign o_word_end    = is_last || (r_cnt == CNT_W'(WORD_BITS - 1));
    assign o_last        = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
            end else if (take) begin
                if (is_last) begin
                    r_active <= 1'b0;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_shift <= i_q_data;
        end else if (take) begin
            r_shift <= r_shift << 1;
        end
    end

endmodule

>>> src/angle_to_sin_cos_dac_serial_unit.sv
// Top level: angle in, two serial DAC words (cos on channel B, sin on channel A) out.
// Path from angle accept to the first bit word: range reduction folding by pi,
//   16 CORDIC iterations on one rotator, scale, queue.
// Throughput is set by the bit serializer, which shifts out 2*WORD_BITS bits per angle;
//   the front end buffers the next angle while it works and runs ahead through the queue.
// Reset clears control state, empties the queue and sets codes_per_volt to 256000.
module angle_to_sin_cos_dac_serial_unit #(
    parameter int CODE_BITS = 12,
    parameter int WORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [15:0]        i_angle,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_serial_bit,
    output logic                      o_word_select,
    output logic                      o_word_end,
    output logic                      o_last,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [asc_pkg::CPV_W-1:0] i_codes_per_volt
);

    logic [asc_pkg::CPV_W-1:0] r_cpv;
    logic                      q_push, q_pop, q_full, q_empty;
    logic [2*WORD_BITS-1:0]    q_wdata, q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpv <= asc_pkg::CPV_RESET;
        end else if (i_cfg_valid) begin
            r_cpv <= i_codes_per_volt;
        end
    end

    asc_front #(
        .CODE_BITS(CODE_BITS),
        .WORD_BITS(WORD_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_angle          (i_angle),
        .i_codes_per_volt (r_cpv),
        .i_q_full         (q_full),
        .o_push           (q_push),
        .o_push_data      (q_wdata)
    );

    asc_queue #(
        .DATA_W(2 * WORD_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    asc_back #(
        .WORD_BITS(WORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rdata),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_serial_bit  (o_serial_bit),
        .o_word_select (o_word_select),
        .o_word_end    (o_word_end),
        .o_last        (o_last)
    );

endmodule

>>> dv/tb_angle_to_sin_cos_dac_serial_unit.sv
// Self-checking testbench for the angle to sin/cos serial DAC unit, with a CORDIC predictor.
module tb_angle_to_sin_cos_dac_serial_unit;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ATAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2};
    localparam logic [asc_pkg::CPV_W-1:0] GAIN_MAX = '1;

    typedef struct packed {
        logic serial_bit;
        logic word_select;
        logic word_end;
        logic last;
    } t_dac_bit;

    typedef struct packed {
        logic                      wr_gain;
        logic [asc_pkg::CPV_W-1:0] gain;
        logic [15:0]               angle;
        logic                      typed;
        logic [15:0]               cos_word;
        logic [15:0]               sin_word;
    } t_stim_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [15:0]         i_angle;
    logic                       o_valid;
    logic                       i_ready;
    logic                       o_serial_bit;
    logic                       o_word_select;
    logic                       o_word_end;
    logic                       o_last;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [asc_pkg::CPV_W-1:0]  i_codes_per_volt;

    t_dac_bit                  pending_bits [$];
    logic [asc_pkg::CPV_W-1:0] gain_now;
    bit                        idle_on;
    int unsigned               fail_cnt;
    int unsigned               n_angles;
    int unsigned               n_gains;
    int unsigned               n_bits;
    int unsigned               cycle_cnt;
    t_stim_row                 dir_tab [25];

    angle_to_sin_cos_dac_serial_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_angle         (i_angle),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_serial_bit    (o_serial_bit),
        .o_word_select   (o_word_select),
        .o_word_end      (o_word_end),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_codes_per_volt(i_codes_per_volt)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // {cos word, sin word} for one angle at the given gain
    function automatic logic [31:0] dac_words(input logic signed [15:0] ang,
                                              input logic [asc_pkg::CPV_W-1:0] gain);
        int          z;
        int          x;
        int          y;
        int          nx;
        int          q14 [2];
        int          v14;
        bit          flip;
        logic [63:0] prod;
        logic [11:0] code [2];
        z = int'(ang) * 16;
        x = 39796;
        y = 0;
        flip = 1'b0;
        // fold into [-pi/2, pi/2], each fold flips the sign of the vector
        while (z > 102944) begin
            z -= 205887;
            flip = !flip;
        end
        while (z < -102944) begin
            z += 205887;
            flip = !flip;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ATAN_Q16[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ATAN_Q16[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        q14[0] = (x + 2) >>> 2;
        q14[1] = (y + 2) >>> 2;
        for (int k = 0; k < 2; k++) begin
            v14 = 2 * q14[k] + 40960;
            if (v14 < 0) v14 = 0;
            prod = 64'(v14) * 64'(gain) + 64'h20_0000;
            code[k] = prod[33:22];   // wraps on overflow
        end
        return {asc_pkg::HDR_CH_B | 16'(code[0]), asc_pkg::HDR_CH_A | 16'(code[1])};
    endfunction

    task automatic post_angle(input logic signed [15:0] ang, input logic typed,
                              input logic [15:0] cw, input logic [15:0] sw);
        logic [31:0] words;
        logic [15:0] cur;
        t_dac_bit    nb;
        words = typed ? {cw, sw} : dac_words(ang, gain_now);
        i_valid <= 1'b1;
        i_angle <= ang;
        do @(posedge i_clk); while (!o_ready);
        for (int w = 0; w < 2; w++) begin
            cur = (w == 0) ? words[31:16] : words[15:0];
            for (int b = 0; b < 16; b++) begin
                nb.serial_bit  = cur[15-b];
                nb.word_select = (w == 1);
                nb.word_end    = (b == 15);
                nb.last        = (w == 1) && (b == 15);
                pending_bits.push_back(nb);
            end
        end
        n_angles++;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic wait_dac_idle();
        i_valid <= 1'b0;
        while (pending_bits.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_gain(input logic [asc_pkg::CPV_W-1:0] g);
        i_cfg_valid      <= 1'b1;
        i_codes_per_volt <= g;
        do @(posedge i_clk); while (!o_cfg_ready);
        gain_now = g;
        n_gains++;
        i_cfg_valid <= 1'b0;
    endtask

    // output side: random stall bursts
    initial begin
        i_ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 15) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_dac_bit want;
        t_dac_bit got;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_serial_bit, o_word_select, o_word_end, o_last};
            if (pending_bits.size() == 0) begin
                $error("unexpected serial word: %b", got);
                fail_cnt++;
            end else begin
                want = pending_bits.pop_front();
                n_bits++;
                if (got.serial_bit !== want.serial_bit) begin
                    $error("serial_bit: expected %0b, got %0b", want.serial_bit, got.serial_bit);
                    fail_cnt++;
                end
                if (got.word_select !== want.word_select) begin
                    $error("word_select: expected %0b, got %0b",
                           want.word_select, got.word_select);
                    fail_cnt++;
                end
                if (got.word_end !== want.word_end) begin
                    $error("word_end: expected %0b, got %0b", want.word_end, got.word_end);
                    fail_cnt++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, got.last);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int                        tmp;
        logic signed [15:0]        ang;
        logic [asc_pkg::CPV_W-1:0] ph_gain;
        cycle_cnt        = 0;
        fail_cnt         = 0;
        n_angles         = 0;
        n_gains          = 0;
        n_bits           = 0;
        gain_now         = asc_pkg::CPV_RESET;
        idle_on          = 1'b1;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_angle          <= '0;
        i_cfg_valid      <= 1'b0;
        i_codes_per_volt <= '0;

        // zero gain leaves only the half-code rounding, so both codes are 0
        dir_tab = '{
            '{1'b0, '0,       16'sd0,      1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       16'sd32767,  1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       -16'sd32768, 1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       16'sd1,      1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       -16'sd1,     1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       16'sd6434,   1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       -16'sd6434,  1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       16'sd12868,  1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       -16'sd12868, 1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       16'sd25736,  1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       16'sd4096,   1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       -16'sd4096,  1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       16'sd3217,   1'b0, 16'h0, 16'h0},
            '{1'b1, '0,       16'sd0,      1'b1, asc_pkg::HDR_CH_B, asc_pkg::HDR_CH_A},
            '{1'b0, '0,       16'sd32767,  1'b1, asc_pkg::HDR_CH_B, asc_pkg::HDR_CH_A},
            '{1'b0, '0,       -16'sd32768, 1'b1, asc_pkg::HDR_CH_B, asc_pkg::HDR_CH_A},
            '{1'b0, '0,       16'sd12868,  1'b1, asc_pkg::HDR_CH_B, asc_pkg::HDR_CH_A},
            '{1'b1, GAIN_MAX, 16'sd0,      1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       16'sd6434,   1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       -16'sd6434,  1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       16'sd12868,  1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       16'sd32767,  1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       -16'sd32768, 1'b0, 16'h0, 16'h0},
            '{1'b1, 20'd1,    16'sd0,      1'b0, 16'h0, 16'h0},
            '{1'b0, '0,       16'sd6434,   1'b0, 16'h0, 16'h0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first rows run on the reset gain
        foreach (dir_tab[r]) begin
            if (dir_tab[r].wr_gain) begin
                wait_dac_idle();
                set_gain(dir_tab[r].gain);
            end
            post_angle(dir_tab[r].angle, dir_tab[r].typed,
                       dir_tab[r].cos_word, dir_tab[r].sin_word);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       ph_gain = 20'($urandom_range(0, 20'hFFFFF));
                1:       ph_gain = asc_pkg::CPV_RESET;
                2:       ph_gain = 20'($urandom_range(180000, 420000));
                default: ph_gain = 20'($urandom_range(0, 20'hFFFFF));
            endcase
            wait_dac_idle();
            set_gain(ph_gain);
            for (int k = 0; k < 49; k++) begin
                if (ph == 3 && k >= 15) idle_on = 1'b0;
                if (ph == 1 && k == 27) wait_dac_idle();
                case ($urandom_range(0, 3))
                    0: tmp = int'($urandom);
                    1: tmp = int'($urandom_range(0, 12868)) - 6434;
                    2: begin
                        // near the fold points at +-pi/2 and +-pi
                        tmp = ($urandom_range(0, 1) ? 6434 : 12868)
                              + int'($urandom_range(0, 6)) - 3;
                        if ($urandom_range(0, 1)) tmp = -tmp;
                    end
                    default: tmp = int'($urandom_range(0, 51472)) - 25736;
                endcase
                ang = 16'(tmp);
                post_angle(ang, 1'b0, 16'h0, 16'h0);
            end
        end

        wait_dac_idle();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d angles (directed extremes, fold points, random) under %0d gains",
                 n_angles, n_gains + 1);
        $display("Checked %0d serial DAC bits, %0d mismatches", n_bits, fail_cnt);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
